>>> hdl/amge_pkg.sv
// ----------------------------------------------------------------------------
// amge_pkg
// Shared types, constants and operation codes of the adjacency matrix engine.
// ----------------------------------------------------------------------------
package amge_pkg;

  localparam int NODES       = 64;
  localparam int NODE_W      = 6;
  localparam int WEIGHT_BITS = 16;
  localparam int COUNT_W     = 7;
  localparam int CELL_W      = 2 * NODE_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam logic [NODE_W-1:0]  NODE_LAST = 6'd63;

  localparam logic [3:0] OP_ADD_LINK    = 4'd0;
  localparam logic [3:0] OP_REMOVE_LINK = 4'd1;
  localparam logic [3:0] OP_ADD_NODE    = 4'd2;
  localparam logic [3:0] OP_REMOVE_NODE = 4'd3;
  localparam logic [3:0] OP_COUNT       = 4'd4;
  localparam logic [3:0] OP_KTH         = 4'd5;
  localparam logic [3:0] OP_SET_VISIT   = 4'd6;
  localparam logic [3:0] OP_CLR_VISIT   = 4'd7;
  localparam logic [3:0] OP_GET_VISIT   = 4'd8;
  localparam logic [3:0] OP_RESET_VISIT = 4'd9;

  typedef struct packed {
    logic [3:0]                    mode;
    logic [NODE_W-1:0]             node_a;
    logic [NODE_W-1:0]             node_b;
    logic signed [WEIGHT_BITS-1:0] link_weight;
    logic                          both_ways;
    logic [NODE_W-1:0]             neighbour_index;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [NODE_W-1:0]  result_node;
    logic [COUNT_W-1:0] neighbour_total;
    logic               visit_flag;
  } out_beat_t;

  typedef struct packed {
    logic                   m_we;
    logic [CELL_W-1:0]      m_addr;
    logic [WEIGHT_BITS-1:0] m_wdata;
    logic                   c_we;
    logic [NODE_W-1:0]      c_addr;
    logic [COUNT_W-1:0]     c_wdata;
  } store_req_t;

endpackage

>>> hdl/amge_store.sv
// ----------------------------------------------------------------------------
// amge_store
// Weight matrix and usage count memories, one port each, registered reads.
// ----------------------------------------------------------------------------
module amge_store import amge_pkg::*; (
  input  logic                   clk,
  input  store_req_t             req,
  output logic [WEIGHT_BITS-1:0] rd_w,
  output logic [COUNT_W-1:0]     rd_c
);

  logic [WEIGHT_BITS-1:0] matrix [NODES*NODES];
  logic [COUNT_W-1:0]     counts [NODES];

  always_ff @(posedge clk) begin
    if (req.m_we) begin
      matrix[req.m_addr] <= req.m_wdata;
    end
    rd_w <= matrix[req.m_addr];
  end

  always_ff @(posedge clk) begin
    if (req.c_we) begin
      counts[req.c_addr] <= req.c_wdata;
    end
    rd_c <= counts[req.c_addr];
  end

endmodule

>>> hdl/amge_ctrl.sv
// ----------------------------------------------------------------------------
// amge_ctrl
// Sequencer: decodes one beat, walks the stores and drives the count unit.
// ----------------------------------------------------------------------------
module amge_ctrl import amge_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_beat_t               in_data,
  input  logic                   out_free,
  output logic                   done,
  output out_beat_t              result,
  output store_req_t             req,
  input  logic [WEIGHT_BITS-1:0] rd_w,
  input  logic [COUNT_W-1:0]     rd_c
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_CLEAR    = 14'b00000000000010,
    S_DISPATCH = 14'b00000000000100,
    S_RD       = 14'b00000000001000,
    S_WR       = 14'b00000000010000,
    S_CLR_A    = 14'b00000000100000,
    S_CLR_B    = 14'b00000001000000,
    S_SCAN_RD  = 14'b00000010000000,
    S_SCAN_CHK = 14'b00000100000000,
    S_CS_RD    = 14'b00001000000000,
    S_CS_CHK   = 14'b00010000000000,
    S_FIN_RD   = 14'b00100000000000,
    S_FIN_WR   = 14'b01000000000000,
    S_FINISH   = 14'b10000000000000
  } state_t;

  state_t                        state;
  logic [CELL_W-1:0]             clr;
  logic [3:0]                    md;
  logic [NODE_W-1:0]             a, b, k, r, j, row, col;
  logic [WEIGHT_BITS-1:0]        w;
  logic                          both, second;
  logic [NODES-1:0]              visited;
  logic                          inc;
  logic [COUNT_W-1:0]            cnt_step;
  logic                          nz;

  assign in_ready = (state == S_IDLE);
  assign done     = (state == S_FINISH) && out_free;
  assign nz       = (rd_w != '0);

  // shared count unit
  assign inc      = (md == OP_ADD_LINK);
  assign cnt_step = inc ? rd_c + 7'd1 : rd_c - 7'd1;

  always_comb begin
    req         = '0;
    req.m_addr  = {row, col};
    req.c_addr  = col;
    req.c_wdata = cnt_step;
    case (state)
      S_CLEAR: begin
        req.m_addr = clr;
        req.m_we   = 1'b1;
        req.c_addr = clr[NODE_W-1:0];
        req.c_we   = 1'b1;
        req.c_wdata = '0;
      end
      S_WR: begin
        if (inc) begin
          req.m_we    = !nz;
          req.m_wdata = w;
          req.c_we    = !nz && (rd_c != COUNT_MAX);
        end else begin
          req.c_we = ($signed(rd_w) > 0) && (rd_c != '0);
        end
      end
      S_CLR_A: req.m_we = 1'b1;
      S_CLR_B: begin
        req.m_addr = {col, row};
        req.m_we   = 1'b1;
      end
      S_CS_RD: req.c_addr = r;
      S_CS_CHK: begin
        req.c_addr  = r;
        req.c_we    = (rd_c == '0);
        req.c_wdata = 7'd1;
      end
      S_FIN_RD: req.c_addr = a;
      S_FIN_WR: begin
        req.c_addr = a;
        req.c_we   = (md == OP_REMOVE_NODE) && (rd_c != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      visited <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            md     <= in_data.mode;
            a      <= in_data.node_a;
            b      <= in_data.node_b;
            w      <= in_data.link_weight;
            both   <= in_data.both_ways;
            k      <= in_data.neighbour_index;
            result <= '0;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          second <= 1'b0;
          r      <= '0;
          j      <= '0;
          case (md)
            OP_ADD_LINK, OP_REMOVE_LINK: begin
              row   <= b;
              col   <= a;
              state <= S_RD;
            end
            OP_ADD_NODE: state <= S_CS_RD;
            OP_REMOVE_NODE, OP_KTH: begin
              row   <= '0;
              col   <= a;
              state <= S_SCAN_RD;
            end
            OP_COUNT: state <= S_FIN_RD;
            OP_SET_VISIT: begin
              visited[a] <= 1'b1;
              state      <= S_FINISH;
            end
            OP_CLR_VISIT: begin
              visited[a] <= 1'b0;
              state      <= S_FINISH;
            end
            OP_GET_VISIT: begin
              result.visit_flag <= visited[a];
              state             <= S_FINISH;
            end
            OP_RESET_VISIT: begin
              visited <= '0;
              state   <= S_FINISH;
            end
            default: state <= S_FINISH;
          endcase
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (!second && (!inc || both)) begin
            row    <= col;
            col    <= row;
            second <= 1'b1;
            state  <= S_RD;
          end else if (inc) begin
            state <= S_FINISH;
          end else begin
            state <= S_CLR_A;
          end
        end
        S_CLR_A: state <= S_CLR_B;
        S_CLR_B: begin
          if (md == OP_REMOVE_NODE) begin
            if (r == NODE_LAST) begin
              state <= S_FIN_RD;
            end else begin
              r     <= r + 1'b1;
              row   <= r + 1'b1;
              col   <= a;
              state <= S_SCAN_RD;
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (nz && (md == OP_REMOVE_NODE)) begin
            row    <= a;
            col    <= r;
            second <= 1'b0;
            state  <= S_RD;
          end else if (nz && (j == k)) begin
            result.found       <= 1'b1;
            result.result_node <= r;
            state              <= S_FINISH;
          end else begin
            if (nz) begin
              j <= j + 1'b1;
            end
            if (r == NODE_LAST) begin
              state <= (md == OP_REMOVE_NODE) ? S_FIN_RD : S_FINISH;
            end else begin
              r     <= r + 1'b1;
              row   <= r + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_CS_RD: state <= S_CS_CHK;
        S_CS_CHK: begin
          if (rd_c == '0) begin
            result.found       <= 1'b1;
            result.result_node <= r;
            state              <= S_FINISH;
          end else if (r == NODE_LAST) begin
            state <= S_FINISH;
          end else begin
            r     <= r + 1'b1;
            state <= S_CS_RD;
          end
        end
        S_FIN_RD: state <= S_FIN_WR;
        S_FIN_WR: begin
          if ((md == OP_COUNT) && (rd_c != '0)) begin
            result.neighbour_total <= cnt_step;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/adjacency_matrix_graph_engine.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_engine
// Graph store with link weight matrix, usage counts and visited flags.
// ----------------------------------------------------------------------------
// Usage: one request beat on in_data (valid/ready) gives exactly one response
// beat on out_data (valid/ready), in order.
// After rst the block sweeps the 4096-entry weight matrix and the count table
// one entry per cycle; in_ready stays low until the sweep is done.
// One beat at a time: in_ready drops after a beat is taken and rises again
// once its response is loaded into the output register.
// The time to a response is set by the single-port memories and the sequencer
// walk: add node reads the count table until it finds a free entry; kth
// neighbour reads the matrix entries of node_a until it finds the match;
// remove node reads every one of those entries and clears each link found.
// The response waits in its output register while out_ready is low; a
// following request may be taken, and its response holds in the sequencer
// until the output register frees.
module adjacency_matrix_graph_engine import amge_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  store_req_t             req;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [COUNT_W-1:0]     rd_c;
  logic                   out_free;
  logic                   done;
  out_beat_t              result;

  assign out_free = !out_valid || out_ready;

  amge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .done     (done),
    .result   (result),
    .req      (req),
    .rd_w     (rd_w),
    .rd_c     (rd_c)
  );

  amge_store u_store (
    .clk  (clk),
    .req  (req),
    .rd_w (rd_w),
    .rd_c (rd_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data <= result;
    end
  end

endmodule

>>> hdl/amge_checker.sv
// ----------------------------------------------------------------------------
// amge_checker
// Port-level checks of the adjacency matrix engine.
// ----------------------------------------------------------------------------
module amge_checker import amge_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response beat dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request beat taken while busy");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready or valid during clearing sweep");

  a_node_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.result_node == '0)
    else $error("result node set without found");

endmodule

bind adjacency_matrix_graph_engine amge_checker u_amge_checker (.*);

>>> dv/amge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amge_tb_checker
// Watches the request and response channels of the graph engine, keeps its
// own copy of the weight matrix, usage counts and visited flags, predicts each
// response beat in order and compares it field by field.
// ----------------------------------------------------------------------------
module amge_tb_checker import amge_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending
);

  logic signed [WEIGHT_BITS-1:0] link_w [NODES][NODES];
  logic [COUNT_W-1:0]            usage [NODES];
  logic                          visited [NODES];
  out_beat_t                     expected_q [$];

  function automatic void usage_up(int n);
    if (usage[n] < COUNT_MAX) usage[n] = usage[n] + 7'd1;
  endfunction

  function automatic void usage_down(int n);
    if (usage[n] != '0) usage[n] = usage[n] - 7'd1;
  endfunction

  function automatic void unlink(int a, int b);
    if (link_w[b][a] > 0) usage_down(a);
    if (link_w[a][b] > 0) usage_down(b);
    link_w[a][b] = '0;
    link_w[b][a] = '0;
  endfunction

  function automatic out_beat_t graph_step(in_beat_t req);
    out_beat_t res;
    int        a, b, j;
    res = '0;
    a = int'(req.node_a);
    b = int'(req.node_b);
    case (req.mode)
      OP_ADD_LINK: begin
        if (link_w[b][a] == 0) begin
          link_w[b][a] = req.link_weight;
          usage_up(a);
        end
        if (req.both_ways && link_w[a][b] == 0) begin
          link_w[a][b] = req.link_weight;
          usage_up(b);
        end
      end
      OP_REMOVE_LINK: unlink(a, b);
      OP_ADD_NODE: begin
        for (int r = 0; r < NODES; r++) begin
          if (usage[r] == '0) begin
            usage[r] = 7'd1;
            res.found = 1'b1;
            res.result_node = NODE_W'(r);
            break;
          end
        end
      end
      OP_REMOVE_NODE: begin
        for (int r = 0; r < NODES; r++)
          if (link_w[r][a] != 0) unlink(r, a);
        usage_down(a);
      end
      OP_COUNT: if (usage[a] != '0) res.neighbour_total = usage[a] - 7'd1;
      OP_KTH: begin
        j = 0;
        for (int r = 0; r < NODES; r++) begin
          if (link_w[r][a] != 0) begin
            if (j == int'(req.neighbour_index)) begin
              res.found = 1'b1;
              res.result_node = NODE_W'(r);
              break;
            end
            j++;
          end
        end
      end
      OP_SET_VISIT:   visited[a] = 1'b1;
      OP_CLR_VISIT:   visited[a] = 1'b0;
      OP_GET_VISIT:   res.visit_flag = visited[a];
      OP_RESET_VISIT: for (int r = 0; r < NODES; r++) visited[r] = 1'b0;
      default: ;
    endcase
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      for (int r = 0; r < NODES; r++) begin
        usage[r] = '0;
        visited[r] = 1'b0;
        for (int c = 0; c < NODES; c++) link_w[r][c] = '0;
      end
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(graph_step(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("response beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_data.found !== want.found)
            $error("found: expected %0d, got %0d", want.found, out_data.found);
          if (out_data.result_node !== want.result_node)
            $error("result_node: expected %0d, got %0d", want.result_node,
                   out_data.result_node);
          if (out_data.neighbour_total !== want.neighbour_total)
            $error("neighbour_total: expected %0d, got %0d", want.neighbour_total,
                   out_data.neighbour_total);
          if (out_data.visit_flag !== want.visit_flag)
            $error("visit_flag: expected %0d, got %0d", want.visit_flag,
                   out_data.visit_flag);
          if (out_data !== want) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

>>> dv/adjacency_matrix_graph_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_engine_tb
// Drives directed and random request beats into the graph engine under
// varying sender and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_engine_tb;
  import amge_pkg::*;

  localparam int LIMIT = 3_000_000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  int        cycles;
  int        send_idle;
  int        recv_idle;
  int        sent;

  adjacency_matrix_graph_engine uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  amge_tb_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(99) >= recv_idle);
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [NODE_W-1:0] pick_node();
    case ($urandom_range(3))
      0: return 6'($urandom);
      1: return NODE_LAST;
      default: return 6'($urandom_range(7));
    endcase
  endfunction

  task automatic send(logic [3:0] mode, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                      logic [WEIGHT_BITS-1:0] w, logic bw, logic [NODE_W-1:0] k);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= '{mode, a, b, w, bw, k};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    sent++;
    @(posedge clk);
  endtask

  task automatic random_beat();
    logic [3:0] m;
    logic [WEIGHT_BITS-1:0] w;
    m = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    if ($urandom_range(5) == 0) m = OP_ADD_LINK;
    w = 16'($urandom);
    if ($urandom_range(7) == 0) w = '0;
    send(m, pick_node(), pick_node(), w, 1'($urandom), 6'($urandom_range(3) == 0 ?
         $urandom : $urandom_range(4)));
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    send_idle = 0;
    recv_idle = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send(OP_GET_VISIT, 6'd0, 6'd0, '0, 1'b0, '0);
    send(OP_ADD_NODE, '0, '0, '0, 1'b0, '0);
    send(OP_ADD_LINK, 6'd0, NODE_LAST, 16'sh7fff, 1'b1, '0);
    send(OP_ADD_LINK, 6'd0, 6'd1, 16'sh8000, 1'b0, '0);
    send(OP_ADD_LINK, 6'd0, 6'd2, 16'sh0000, 1'b0, '0);
    send(OP_ADD_LINK, 6'd3, 6'd3, 16'sh0005, 1'b1, '0);
    send(OP_COUNT, 6'd0, '0, '0, 1'b0, '0);
    send(OP_KTH, 6'd0, '0, '0, 1'b0, 6'd0);
    send(OP_KTH, 6'd0, '0, '0, 1'b0, 6'd1);
    send(OP_KTH, 6'd0, '0, '0, 1'b0, NODE_LAST);
    send(OP_REMOVE_LINK, 6'd0, 6'd1, '0, 1'b0, '0);
    send(OP_REMOVE_LINK, 6'd3, 6'd3, '0, 1'b0, '0);
    send(OP_COUNT, 6'd3, '0, '0, 1'b0, '0);
    send(OP_REMOVE_NODE, 6'd0, '0, '0, 1'b0, '0);
    send(OP_REMOVE_NODE, 6'd0, '0, '0, 1'b0, '0);
    send(OP_COUNT, NODE_LAST, '0, '0, 1'b0, '0);
    send(OP_SET_VISIT, NODE_LAST, '0, '0, 1'b0, '0);
    send(OP_GET_VISIT, NODE_LAST, '0, '0, 1'b0, '0);
    send(OP_CLR_VISIT, NODE_LAST, '0, '0, 1'b0, '0);
    send(OP_SET_VISIT, 6'd5, '0, '0, 1'b0, '0);
    send(OP_RESET_VISIT, '0, '0, '0, 1'b0, '0);
    send(OP_GET_VISIT, 6'd5, '0, '0, 1'b0, '0);
    send(4'd15, 6'h3f, 6'h3f, 16'hffff, 1'b1, 6'h3f);
    for (int i = 0; i < 66; i++) send(OP_ADD_NODE, '0, '0, '0, 1'b0, '0);
    while (pending != 0) @(posedge clk);
    send_idle = 26;
    recv_idle = 46;
    for (int i = 0; i < 230; i++) random_beat();
    send_idle = 46;
    recv_idle = 26;
    for (int i = 0; i < 230; i++) random_beat();
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 230; i++) random_beat();
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Sent %0d request beats over all ten modes plus unused codes,", sent);
    $display("under sender and receiver stalls in both mixes and with none.");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
